### src/sts_pkg.sv
// Shared types, character codes and classifiers for the source token scanner.
// Used by sts_step and source_token_scanner_top; no dependencies.
`timescale 1ns / 1ps

package sts_pkg;

   localparam int LengthBits   = 12;
   localparam int KindBits     = 5;
   localparam int ByteBits     = 8;
   localparam int RspDataBits  = ((KindBits + LengthBits + 7) / 8) * 8;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int CountBits    = $clog2(QueueDepth + 1);

   typedef logic [LengthBits-1:0] length_type;
   typedef logic [KindBits-1:0]   kind_type;
   typedef logic [ByteBits-1:0]   byte_type;

   localparam length_type LengthMax  = '1;
   localparam length_type LengthZero = '0;
   localparam length_type LengthOne  = length_type'(1);

   typedef enum logic [3:0] {
      ModeIdle,
      ModeEol,
      ModeString,
      ModePeriod,
      ModeReal,
      ModeSlash,
      ModeComment,
      ModeNameUnd,
      ModeName,
      ModeInt
   } mode_type;

   // token kinds
   localparam kind_type KindEol       = 5'd0;
   localparam kind_type KindEoi       = 5'd1;
   localparam kind_type KindString    = 5'd2;
   localparam kind_type KindError     = 5'd3;
   localparam kind_type KindLParen    = 5'd4;
   localparam kind_type KindRParen    = 5'd5;
   localparam kind_type KindLBrace    = 5'd6;
   localparam kind_type KindRBrace    = 5'd7;
   localparam kind_type KindPeriod    = 5'd8;
   localparam kind_type KindReal      = 5'd9;
   localparam kind_type KindComma     = 5'd10;
   localparam kind_type KindSemicolon = 5'd11;
   localparam kind_type KindPlus      = 5'd12;
   localparam kind_type KindMinus     = 5'd13;
   localparam kind_type KindStar      = 5'd14;
   localparam kind_type KindEqual     = 5'd15;
   localparam kind_type KindSlash     = 5'd16;
   localparam kind_type KindComment   = 5'd17;
   localparam kind_type KindName      = 5'd18;
   localparam kind_type KindInt       = 5'd19;
   localparam kind_type KindLex       = 5'd20;

   // character codes
   localparam byte_type ChTab       = 8'h09;
   localparam byte_type ChLf        = 8'h0A;
   localparam byte_type ChCr        = 8'h0D;
   localparam byte_type ChSpace     = 8'h20;
   localparam byte_type ChQuote     = 8'h22;
   localparam byte_type ChLParen    = 8'h28;
   localparam byte_type ChRParen    = 8'h29;
   localparam byte_type ChStar      = 8'h2A;
   localparam byte_type ChPlus      = 8'h2B;
   localparam byte_type ChComma     = 8'h2C;
   localparam byte_type ChMinus     = 8'h2D;
   localparam byte_type ChPeriod    = 8'h2E;
   localparam byte_type ChSlash     = 8'h2F;
   localparam byte_type ChSemicolon = 8'h3B;
   localparam byte_type ChEqual     = 8'h3D;
   localparam byte_type ChBackslash = 8'h5C;
   localparam byte_type ChUnder     = 8'h5F;
   localparam byte_type ChLowerN    = 8'h6E;
   localparam byte_type ChLowerR    = 8'h72;
   localparam byte_type ChLBrace    = 8'h7B;
   localparam byte_type ChRBrace    = 8'h7D;

   typedef struct packed {
      mode_type   mode;
      length_type length;
      logic       escape;
   } scan_state_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      length_type length;
   } token_type;

   // first: token closed by this byte; second: one-byte token (punctuator or lex error) or eoi
   typedef struct packed {
      token_type first;
      token_type second;
   } step_result_type;

   function automatic logic is_digit(input byte_type b);
      return b inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input byte_type b);
      return b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
   endfunction

   function automatic logic is_word(input byte_type b);
      return (b == ChUnder) || is_digit(b) || is_alpha(b);
   endfunction

   function automatic logic is_nl(input byte_type b);
      return b inside {ChLf, ChCr};
   endfunction

   function automatic kind_type pending_kind(input mode_type m);
      kind_type k;
      case (m)
         ModeEol:                k = KindEol;
         ModeString:             k = KindError;
         ModePeriod:             k = KindPeriod;
         ModeReal:               k = KindReal;
         ModeSlash:              k = KindSlash;
         ModeComment:            k = KindComment;
         ModeNameUnd, ModeName:  k = KindName;
         ModeInt:                k = KindInt;
         default:                k = KindLex;
      endcase
      return k;
   endfunction

endpackage

### src/sts_step.sv
// One scanner step: next scan state and up to two tokens for one byte or end mark.
// Purely combinational; depends on sts_pkg.
`timescale 1ns / 1ps

module sts_step (
   input  sts_pkg::scan_state_type  state,
   input  sts_pkg::byte_type        text_byte,
   input  logic                     is_end,
   output sts_pkg::scan_state_type  state_next,
   output sts_pkg::step_result_type result
);
   import sts_pkg::*;

   length_type len_inc;
   logic       consumed;
   logic       do_start;

   assign len_inc = (state.length == LengthMax) ? state.length : state.length + LengthOne;

   always_comb begin
      state_next = state;
      result     = '0;
      consumed   = 1'b0;
      do_start   = 1'b0;

      if (is_end) begin
         if (state.mode != ModeIdle) begin
            result.first.valid  = 1'b1;
            result.first.kind   = pending_kind(state.mode);
            result.first.length = state.length;
         end
         result.second.valid  = 1'b1;
         result.second.kind   = KindEoi;
         result.second.length = LengthZero;
         state_next.mode   = ModeIdle;
         state_next.length = LengthZero;
         state_next.escape = 1'b0;
      end else if (state.mode == ModeIdle) begin
         do_start = 1'b1;
      end else begin
         // try to extend the open token
         case (state.mode)
            ModeEol: begin
               consumed = is_nl(text_byte);
            end
            ModeString: begin
               if (state.escape) begin
                  consumed = text_byte inside {ChBackslash, ChLowerN, ChLowerR, ChQuote};
                  state_next.escape = 1'b0;
               end else if (text_byte == ChQuote) begin
                  consumed = 1'b1;
               end else if (!is_nl(text_byte)) begin
                  consumed = 1'b1;
                  state_next.escape = (text_byte == ChBackslash);
               end
            end
            ModePeriod: begin
               consumed = is_digit(text_byte);
               if (consumed) state_next.mode = ModeReal;
            end
            ModeReal, ModeInt: begin
               consumed = is_digit(text_byte);
            end
            ModeSlash: begin
               consumed = (text_byte == ChSlash);
               if (consumed) state_next.mode = ModeComment;
            end
            ModeComment: begin
               consumed = !is_nl(text_byte);
            end
            ModeNameUnd: begin
               if (text_byte == ChUnder) begin
                  consumed = 1'b1;
               end else if (is_alpha(text_byte)) begin
                  consumed = 1'b1;
                  state_next.mode = ModeName;
               end
            end
            ModeName: begin
               consumed = is_word(text_byte);
            end
            default: begin
               consumed = 1'b0;
            end
         endcase

         if (consumed) begin
            state_next.length = len_inc;
            // closing quote finishes the string right here
            if (state.mode == ModeString && !state.escape && text_byte == ChQuote) begin
               result.first.valid  = 1'b1;
               result.first.kind   = KindString;
               result.first.length = len_inc;
               state_next.mode   = ModeIdle;
               state_next.length = LengthZero;
               state_next.escape = 1'b0;
            end
         end else begin
            result.first.valid  = 1'b1;
            result.first.kind   = pending_kind(state.mode);
            result.first.length = state.length;
            do_start = 1'b1;
         end
      end

      if (do_start) begin
         state_next.mode   = ModeIdle;
         state_next.length = LengthOne;
         state_next.escape = 1'b0;
         result.second.length = LengthOne;
         case (text_byte)
            ChSpace, ChTab: state_next.length = LengthZero;
            ChLf, ChCr:     state_next.mode = ModeEol;
            ChQuote:        state_next.mode = ModeString;
            ChPeriod:       state_next.mode = ModePeriod;
            ChSlash:        state_next.mode = ModeSlash;
            ChUnder:        state_next.mode = ModeNameUnd;
            ChLParen, ChRParen, ChLBrace, ChRBrace, ChComma, ChSemicolon,
            ChPlus, ChMinus, ChStar, ChEqual: begin
               result.second.valid = 1'b1;
               state_next.length   = LengthZero;
               case (text_byte)
                  ChLParen:    result.second.kind = KindLParen;
                  ChRParen:    result.second.kind = KindRParen;
                  ChLBrace:    result.second.kind = KindLBrace;
                  ChRBrace:    result.second.kind = KindRBrace;
                  ChComma:     result.second.kind = KindComma;
                  ChSemicolon: result.second.kind = KindSemicolon;
                  ChPlus:      result.second.kind = KindPlus;
                  ChMinus:     result.second.kind = KindMinus;
                  ChStar:      result.second.kind = KindStar;
                  default:     result.second.kind = KindEqual;
               endcase
            end
            default: begin
               if (is_alpha(text_byte)) begin
                  state_next.mode = ModeName;
               end else if (is_digit(text_byte)) begin
                  state_next.mode = ModeInt;
               end else begin
                  result.second.valid = 1'b1;
                  result.second.kind  = KindLex;
                  state_next.length   = LengthZero;
               end
            end
         endcase
      end
   end

endmodule

### src/source_token_scanner_top.sv
// Top level of the source token scanner: stream ports, scan state, result queue.
// Depends on sts_pkg and sts_step.
`timescale 1ns / 1ps

// A token enters the result queue with the transaction that closes it; rsp_* shows entries in order.
// Throughput: one req transaction per cycle while req_tready is high; results leave one per
// cycle while rsp_tready is high, so a byte that yields two tokens takes two queue entries
// (four-entry result queue, req_tready low while fewer than two entries are free).
// Reset (synchronous, active high): scanner idle with zero length, queue empty,
// no result pending. No clearing pass.
module source_token_scanner_top (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [sts_pkg::ByteBits-1:0]   req_tdata,   // [7:0] text_byte
   input  logic                           req_tuser,   // [0] is_end
   // token stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [sts_pkg::RspDataBits-1:0] rsp_tdata,  // [4:0] token_kind,
                                                       // [16:5] token_length, rest 0
   output logic                           rsp_tlast    // last_of_run
);
   import sts_pkg::*;

   typedef struct packed {
      kind_type   kind;
      length_type length;
      logic       last;
   } queue_entry_type;

   scan_state_type  state_ff, state_in;
   step_result_type step;

   queue_entry_type                 queue_ff [QueueDepth];
   logic [QueuePtrBits-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0]            count_ff, count_in;

   logic            req_acc, rsp_acc;
   logic [1:0]      num_tokens;
   queue_entry_type entry0, entry1;

   // one scanner step on the byte being taken
   sts_step u_step (
      .state      (state_ff),
      .text_byte  (req_tdata),
      .is_end     (req_tuser),
      .state_next (state_in),
      .result     (step)
   );

   assign req_tready = (count_ff <= CountBits'(QueueDepth - 2));
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_acc    = rsp_tvalid && rsp_tready;

   // pack the valid tokens of this step into consecutive queue slots
   assign num_tokens = {1'b0, step.first.valid} + {1'b0, step.second.valid};

   always_comb begin
      if (step.first.valid) begin
         entry0.kind   = step.first.kind;
         entry0.length = step.first.length;
      end else begin
         entry0.kind   = step.second.kind;
         entry0.length = step.second.length;
      end
      entry0.last   = (num_tokens == 2'd1);
      entry1.kind   = step.second.kind;
      entry1.length = step.second.length;
      entry1.last   = 1'b1;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_acc) begin
         wr_ptr_in = wr_ptr_ff + QueuePtrBits'(num_tokens);
      end
      if (rsp_acc) begin
         rd_ptr_in = rd_ptr_ff + QueuePtrBits'(1);
      end
      count_in = count_ff + (req_acc ? CountBits'(num_tokens) : CountBits'(0))
                          - (rsp_acc ? CountBits'(1) : CountBits'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode   <= ModeIdle;
         state_ff.length <= LengthZero;
         state_ff.escape <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         if (req_acc) state_ff <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (req_acc && num_tokens != 2'd0) begin
         queue_ff[wr_ptr_ff] <= entry0;
      end
      if (req_acc && num_tokens == 2'd2) begin
         queue_ff[wr_ptr_ff + QueuePtrBits'(1)] <= entry1;
      end
   end

   assign rsp_tdata = RspDataBits'({queue_ff[rd_ptr_ff].length, queue_ff[rd_ptr_ff].kind});
   assign rsp_tlast = queue_ff[rd_ptr_ff].last;

   // ---- checks ----
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(QueueDepth))
      else $error("result queue overflow");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == ModeIdle |-> (state_ff.length == LengthZero && !state_ff.escape))
      else $error("idle scanner holds length or escape");

   a_escape_in_string: assert property (@(posedge clock) disable iff (reset)
      state_ff.escape |-> state_ff.mode == ModeString)
      else $error("escape flag outside string");

   a_end_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser) |=> (state_ff.mode == ModeIdle && count_ff != '0))
      else $error("end mark did not reset scanner or queue eoi");

endmodule
